// ===== src/ftss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftss_pkg
// shared constants, types and state codes of the fault trend severity scorer
// ----------------------------------------------------------------------------
package ftss_pkg;

  // window geometry
  localparam int WINDOW_DEPTH = 64;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

  // field widths
  localparam int TIME_W    = 32;
  localparam int RATE_W    = 16;
  localparam int QUEUE_W   = 8;
  localparam int STANDBY_W = 20;
  localparam int SLOPE_W   = 32;
  localparam int FCAST_W   = 20;
  localparam int SCORE_W   = 7;
  localparam int LEVEL_W   = 3;
  localparam int CONF_W    = 10;

  // accumulator widths
  localparam int SX_W     = TIME_W + FILL_W;
  localparam int SX2_W    = 2 * TIME_W + FILL_W;
  localparam int SYR_W    = RATE_W + FILL_W;
  localparam int SYQ_W    = QUEUE_W + FILL_W;
  localparam int SYS_W    = STANDBY_W + FILL_W;
  localparam int SXYR_W   = TIME_W + RATE_W + FILL_W;
  localparam int SXYQ_W   = TIME_W + QUEUE_W + FILL_W;
  localparam int SXYS_W   = TIME_W + STANDBY_W + FILL_W;

  // shared wide unit
  localparam int WIDE_W   = 128;
  localparam int MPLR_W   = SX_W;
  localparam int DCNT_W   = $clog2(WIDE_W);
  localparam int MUL_W    = 32;

  // arithmetic constants
  localparam int unsigned SLOPE_SCALE = 32'd65536000;
  localparam int unsigned CONF_RECIP  = 32'd111849;   // ceil(2^23 / 75)
  localparam int unsigned CONF_BASE   = 32'd655360;
  localparam int unsigned CONF_CAP    = 32'd950;
  localparam int unsigned FCAST_MAX   = 32'd1048575;

  // stream widths
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 144;

  // input mode codes
  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_MUL,
    ST_DEN_SUB,
    ST_MAG_SUB,
    ST_MAG_NEG,
    ST_DIV,
    ST_SAT,
    ST_CONF_MUL,
    ST_CONF_DIV,
    ST_RESULT
  } state_e;

  // which wide product the shift-add multiply is working on
  typedef enum logic [2:0] {
    STEP_NSX2,
    STEP_SXSX,
    STEP_NSXY,
    STEP_SXSY,
    STEP_SCALE
  } step_e;

  // phases of one window entry during the accumulation pass
  typedef enum logic [2:0] {
    PH_READ,
    PH_DIFF,
    PH_XX,
    PH_XR,
    PH_XQ,
    PH_XS,
    PH_ADD_S
  } phase_e;

  // one stored sample
  typedef struct packed {
    logic [STANDBY_W-1:0] standby;
    logic [QUEUE_W-1:0]   queue;
    logic [RATE_W-1:0]    rate;
    logic [TIME_W-1:0]    stamp;
  } sample_t;

endpackage

// ===== src/fault_trend_severity_scorer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fault_trend_severity_scorer_core
// sliding-window least-squares trend and banded severity scoring of samples
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                   | tuser
//  s_axis   | in  | time, fault rate, queue length, standby | mode (1 = clear)
//  m_axis   | out | three slopes, forecast, score, level,   | window_ready
//           |     | confidence, storm flag                  |
//
//  a clear transfer only empties the window and gives no result; a push with
//  fewer than three samples held goes straight to an all-zero result.
//  otherwise each entry held passes an accumulation step (read, diff, xx,
//  xr, xq, xs, add) through one 32x32 multiplier, then shift-add products
//  and 128-step restoring divisions run on one shared 128-bit adder.
//  reset clears the window (fill and head), the sequencer and the output valid.
//  s_axis_tready_o is high only while the sequencer is idle; a finished
//  result waits in the output register while the next transfer is taken.
// ----------------------------------------------------------------------------
module fault_trend_severity_scorer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // time[31:0], fault_rate[47:32], queue_length[55:48], standby_mib[75:56]
  input  logic [ftss_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // mode[0]
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // fault_slope[31:0], queue_slope[63:32], standby_slope[95:64],
  // forecast_faults[115:96], severity_score[122:116],
  // severity_level[125:123], confidence_milli[135:126], storm_warning[136]
  output logic [ftss_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // window_ready[0]
  output logic                           m_axis_tuser_o
);

  localparam int W = ftss_pkg::WIDE_W;

  // window memory
  ftss_pkg::sample_t mem [ftss_pkg::WINDOW_DEPTH];
  ftss_pkg::sample_t rd_q;
  ftss_pkg::sample_t in_smp;

  ftss_pkg::state_e state_q, state_d;
  ftss_pkg::step_e  step_q, step_d;
  ftss_pkg::phase_e ph_q, ph_d;

  logic [ftss_pkg::PTR_W-1:0]  head_q, head_d, ptr_q, ptr_d;
  logic [ftss_pkg::FILL_W-1:0] fill_q, fill_d, idx_q, idx_d;
  logic [1:0]                  fld_q, fld_d;
  logic [ftss_pkg::DCNT_W-1:0] cnt_q, cnt_d;

  logic [ftss_pkg::TIME_W-1:0]   t0_q, t0_d, x_q, x_d;
  logic [ftss_pkg::SX_W-1:0]     sx_q, sx_d;
  logic [ftss_pkg::SX2_W-1:0]    sx2_q, sx2_d;
  logic [ftss_pkg::SYR_W-1:0]    syr_q, syr_d;
  logic [ftss_pkg::SYQ_W-1:0]    syq_q, syq_d;
  logic [ftss_pkg::SYS_W-1:0]    sys_q, sys_d;
  logic [ftss_pkg::SXYR_W-1:0]   sxyr_q, sxyr_d;
  logic [ftss_pkg::SXYQ_W-1:0]   sxyq_q, sxyq_d;
  logic [ftss_pkg::SXYS_W-1:0]   sxys_q, sxys_d;

  logic [W-1:0]                acc_q, acc_d, mcand_q, mcand_d;
  logic [W-1:0]                den_q, den_d, a_q, a_d, wc_q, wc_d;
  logic [ftss_pkg::MPLR_W-1:0] mplr_q, mplr_d;
  logic                        den_zero_q, den_zero_d, neg_q, neg_d;

  logic [2*ftss_pkg::MUL_W-1:0] prod_q;
  logic [ftss_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic                         prod_en;

  logic signed [ftss_pkg::SLOPE_W-1:0] hf_q, hf_d, dq_q, dq_d, sb_q, sb_d;
  logic [ftss_pkg::RATE_W-1:0]    rate_q, rate_d;
  logic [ftss_pkg::QUEUE_W-1:0]   queue_q, queue_d;
  logic [ftss_pkg::STANDBY_W-1:0] stby_q, stby_d;
  logic                           win_ok_q, win_ok_d;

  logic                         m_valid_q, m_valid_d, m_user_q, m_user_d;
  logic [ftss_pkg::M_TDATA_W-1:0] m_data_q, m_data_d;

  // shared adder
  logic [W-1:0] au_a, au_b;
  logic         au_sub;
  logic [W:0]   au_sum;
  logic         au_ge;

  logic s_acc, out_free;
  logic [ftss_pkg::PTR_W-1:0]  head_nxt, ptr_inc;
  logic [ftss_pkg::FILL_W-1:0] fill_nxt;
  logic [ftss_pkg::FILL_W:0]   first_sum, first_wrap;
  logic [W-1:0]                sxy_sel, sy_sel;
  logic [ftss_pkg::SLOPE_W-1:0] slope_sat;

  // result fields
  logic signed [39:0]               hf_ext, fc_val;
  logic [ftss_pkg::FCAST_W-1:0]     fcast;
  logic [ftss_pkg::SCORE_W-1:0]     score;
  logic [ftss_pkg::LEVEL_W-1:0]     level;
  logic [ftss_pkg::CONF_W-1:0]      conf;
  logic                             storm;
  logic [32:0]                      absl, absl_cap;
  logic [15:0]                      fill_ext;
  logic [4:0]                       nc;

  assign s_axis_tready_o = (state_q == ftss_pkg::ST_IDLE);
  assign s_acc           = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = !m_valid_q | m_axis_tready_i;
  assign in_smp          = s_axis_tdata_i[75:0];

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // window bookkeeping
  assign head_nxt = (head_q == ftss_pkg::PTR_W'(ftss_pkg::WINDOW_DEPTH - 1)) ?
                    '0 : head_q + 1'b1;
  assign fill_nxt = (fill_q < ftss_pkg::FILL_W'(ftss_pkg::WINDOW_DEPTH)) ?
                    fill_q + 1'b1 : fill_q;
  assign first_sum = (ftss_pkg::FILL_W+1)'(head_nxt)
                   + (ftss_pkg::FILL_W+1)'(ftss_pkg::WINDOW_DEPTH)
                   - (ftss_pkg::FILL_W+1)'(fill_nxt);
  assign first_wrap = (first_sum >= (ftss_pkg::FILL_W+1)'(ftss_pkg::WINDOW_DEPTH)) ?
                      first_sum - (ftss_pkg::FILL_W+1)'(ftss_pkg::WINDOW_DEPTH) :
                      first_sum;
  assign ptr_inc = (ptr_q == ftss_pkg::PTR_W'(ftss_pkg::WINDOW_DEPTH - 1)) ?
                   '0 : ptr_q + 1'b1;

  // shared 128-bit add / subtract
  assign au_sum = {1'b0, au_a} + {1'b0, (au_sub ? ~au_b : au_b)} + (W+1)'(au_sub);
  assign au_ge  = au_sum[W];

  always_comb begin
    au_a   = '0;
    au_b   = '0;
    au_sub = 1'b0;
    unique case (state_q)
      ftss_pkg::ST_MUL: begin
        au_a = acc_q;
        au_b = mcand_q;
      end
      ftss_pkg::ST_DEN_SUB: begin
        au_a   = den_q;
        au_b   = acc_q;
        au_sub = 1'b1;
      end
      ftss_pkg::ST_MAG_SUB: begin
        au_a   = a_q;
        au_b   = acc_q;
        au_sub = 1'b1;
      end
      ftss_pkg::ST_MAG_NEG: begin
        au_b   = a_q;
        au_sub = 1'b1;
      end
      ftss_pkg::ST_DIV: begin
        au_a   = {acc_q[W-2:0], wc_q[W-1]};
        au_b   = den_q;
        au_sub = 1'b1;
      end
      default: ;
    endcase
  end

  // per-field sums for the slope in progress
  always_comb begin
    case (fld_q)
      2'd0: begin
        sxy_sel = W'(sxyr_q);
        sy_sel  = W'(syr_q);
      end
      2'd1: begin
        sxy_sel = W'(sxyq_q);
        sy_sel  = W'(syq_q);
      end
      2'd2: begin
        sxy_sel = W'(sxys_q);
        sy_sel  = W'(sys_q);
      end
      default: begin
        sxy_sel = '0;
        sy_sel  = '0;
      end
    endcase
  end

  // truncated quotient to saturated q16.16
  always_comb begin
    if (neg_q) begin
      if ((wc_q[W-1:32] != '0) || (wc_q[31:0] > 32'h8000_0000)) begin
        slope_sat = 32'h8000_0000;
      end else begin
        slope_sat = 32'(33'd0 - {1'b0, wc_q[31:0]});
      end
    end else begin
      if (wc_q[W-1:31] != '0) begin
        slope_sat = 32'h7FFF_FFFF;
      end else begin
        slope_sat = wc_q[31:0];
      end
    end
  end

  // confidence operands
  assign fill_ext = 16'(fill_q);
  assign nc       = (fill_ext < 16'd30) ? 5'(fill_ext) : 5'd30;
  assign absl     = hf_q[31] ? 33'd0 - {hf_q[31], hf_q} : {1'b0, hf_q};
  assign absl_cap = (absl > 33'(ftss_pkg::CONF_BASE)) ? 33'(ftss_pkg::CONF_BASE) : absl;

  // shared 32x32 multiplier operands
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    prod_en = 1'b0;
    unique case (state_q)
      ftss_pkg::ST_ACC: begin
        prod_en = 1'b1;
        mul_a   = x_q;
        case (ph_q)
          ftss_pkg::PH_XX: mul_b = x_q;
          ftss_pkg::PH_XR: mul_b = 32'(rd_q.rate);
          ftss_pkg::PH_XQ: mul_b = 32'(rd_q.queue);
          ftss_pkg::PH_XS: mul_b = 32'(rd_q.standby);
          default:         mul_b = '0;
        endcase
      end
      ftss_pkg::ST_CONF_MUL: begin
        prod_en = 1'b1;
        mul_a   = 32'(nc) * 32'd1000;
        mul_b   = 32'(ftss_pkg::CONF_BASE) + 32'(absl_cap);
      end
      ftss_pkg::ST_CONF_DIV: begin
        prod_en = 1'b1;
        mul_a   = 32'(prod_q[35:19]);
        mul_b   = ftss_pkg::CONF_RECIP;
      end
      default: ;
    endcase
  end

  // result fields from the newest sample and the slopes
  always_comb begin
    logic [23:0] fc_q16;
    logic [6:0]  pts;
    logic [10:0] conf_raw;
    hf_ext = 40'(hf_q);
    fc_val = $signed({8'd0, rate_q, 16'd0}) + (hf_ext <<< 5) - (hf_ext <<< 1);
    fc_q16 = fc_val[39:16];
    if (fc_val[39]) begin
      fcast = '0;
    end else if (fc_q16 > 24'(ftss_pkg::FCAST_MAX)) begin
      fcast = ftss_pkg::FCAST_W'(ftss_pkg::FCAST_MAX);
    end else begin
      fcast = fc_q16[19:0];
    end

    pts = '0;
    if (rate_q >= 16'd500)      pts = pts + 7'd40;
    else if (rate_q >= 16'd200) pts = pts + 7'd30;
    else if (rate_q >= 16'd100) pts = pts + 7'd20;
    else if (rate_q >= 16'd50)  pts = pts + 7'd10;
    if (hf_q > 32'sd655360)      pts = pts + 7'd25;
    else if (hf_q > 32'sd327680) pts = pts + 7'd18;
    else if (hf_q > 32'sd131072) pts = pts + 7'd10;
    else if (hf_q > 32'sd65536)  pts = pts + 7'd5;
    if (queue_q >= 8'd3)      pts = pts + 7'd20;
    else if (queue_q >= 8'd2) pts = pts + 7'd13;
    else if (queue_q >= 8'd1) pts = pts + 7'd7;
    if (stby_q < 20'd512)       pts = pts + 7'd15;
    else if (stby_q < 20'd1024) pts = pts + 7'd10;
    else if (stby_q < 20'd2048) pts = pts + 7'd5;
    score = pts;

    if (score >= 7'd70)      level = 3'd4;
    else if (score >= 7'd50) level = 3'd3;
    else if (score >= 7'd30) level = 3'd2;
    else if (score >= 7'd15) level = 3'd1;
    else                     level = 3'd0;

    conf_raw = prod_q[33:23];
    conf = (conf_raw > 11'(ftss_pkg::CONF_CAP)) ? ftss_pkg::CONF_W'(ftss_pkg::CONF_CAP) :
           conf_raw[9:0];

    storm = (score >= 7'd50) && ((hf_q > 32'sd196608) || (dq_q > 32'sd32768)) &&
            ((stby_q < 20'd1024) || (rate_q >= 16'd100));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ftss_pkg::ST_IDLE: begin
        if (s_acc && (s_axis_tuser_i == ftss_pkg::MODE_PUSH)) begin
          state_d = (fill_nxt < ftss_pkg::FILL_W'(3)) ? ftss_pkg::ST_RESULT :
                    ftss_pkg::ST_ACC;
        end
      end
      ftss_pkg::ST_ACC: begin
        if ((ph_q == ftss_pkg::PH_ADD_S) && (idx_q == fill_q - 1'b1)) begin
          state_d = ftss_pkg::ST_MUL;
        end
      end
      ftss_pkg::ST_MUL: begin
        if (mplr_q == '0) begin
          case (step_q)
            ftss_pkg::STEP_SXSX:  state_d = ftss_pkg::ST_DEN_SUB;
            ftss_pkg::STEP_SXSY:  state_d = ftss_pkg::ST_MAG_SUB;
            ftss_pkg::STEP_SCALE: state_d = den_zero_q ? ftss_pkg::ST_SAT : ftss_pkg::ST_DIV;
            default:              state_d = ftss_pkg::ST_MUL;
          endcase
        end
      end
      ftss_pkg::ST_DEN_SUB: state_d = ftss_pkg::ST_MUL;
      ftss_pkg::ST_MAG_SUB: state_d = au_ge ? ftss_pkg::ST_MUL : ftss_pkg::ST_MAG_NEG;
      ftss_pkg::ST_MAG_NEG: state_d = ftss_pkg::ST_MUL;
      ftss_pkg::ST_DIV: begin
        if (cnt_q == ftss_pkg::DCNT_W'(W - 1)) state_d = ftss_pkg::ST_SAT;
      end
      ftss_pkg::ST_SAT: begin
        state_d = (fld_q == 2'd2) ? ftss_pkg::ST_CONF_MUL : ftss_pkg::ST_MUL;
      end
      ftss_pkg::ST_CONF_MUL: state_d = ftss_pkg::ST_CONF_DIV;
      ftss_pkg::ST_CONF_DIV: state_d = ftss_pkg::ST_RESULT;
      ftss_pkg::ST_RESULT: begin
        if (out_free) state_d = ftss_pkg::ST_IDLE;
      end
      default: state_d = ftss_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d = head_q;  fill_d = fill_q;  ptr_d = ptr_q;  idx_d = idx_q;
    ph_d = ph_q;      step_d = step_q;  fld_d = fld_q;  cnt_d = cnt_q;
    t0_d = t0_q;      x_d = x_q;
    sx_d = sx_q;      sx2_d = sx2_q;
    syr_d = syr_q;    syq_d = syq_q;    sys_d = sys_q;
    sxyr_d = sxyr_q;  sxyq_d = sxyq_q;  sxys_d = sxys_q;
    acc_d = acc_q;    mcand_d = mcand_q; mplr_d = mplr_q;
    den_d = den_q;    a_d = a_q;        wc_d = wc_q;
    den_zero_d = den_zero_q;            neg_d = neg_q;
    hf_d = hf_q;      dq_d = dq_q;      sb_d = sb_q;
    rate_d = rate_q;  queue_d = queue_q; stby_d = stby_q;
    win_ok_d = win_ok_q;
    m_valid_d = m_valid_q & !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    unique case (state_q)
      ftss_pkg::ST_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser_i == ftss_pkg::MODE_CLEAR) begin
            head_d = '0;
            fill_d = '0;
          end else begin
            head_d   = head_nxt;
            fill_d   = fill_nxt;
            ptr_d    = ftss_pkg::PTR_W'(first_wrap);
            idx_d    = '0;
            ph_d     = ftss_pkg::PH_READ;
            sx_d = '0; sx2_d = '0; syr_d = '0; syq_d = '0; sys_d = '0;
            sxyr_d = '0; sxyq_d = '0; sxys_d = '0;
            rate_d   = in_smp.rate;
            queue_d  = in_smp.queue;
            stby_d   = in_smp.standby;
            win_ok_d = (fill_nxt >= ftss_pkg::FILL_W'(3));
          end
        end
      end

      // one window entry at a time through the multiplier
      ftss_pkg::ST_ACC: begin
        case (ph_q)
          ftss_pkg::PH_READ: ph_d = ftss_pkg::PH_DIFF;
          ftss_pkg::PH_DIFF: begin
            if (idx_q == '0) begin
              t0_d = rd_q.stamp;
              x_d  = '0;
            end else begin
              x_d = rd_q.stamp - t0_q;
            end
            ph_d = ftss_pkg::PH_XX;
          end
          ftss_pkg::PH_XX: begin
            sx_d  = sx_q + ftss_pkg::SX_W'(x_q);
            syr_d = syr_q + ftss_pkg::SYR_W'(rd_q.rate);
            syq_d = syq_q + ftss_pkg::SYQ_W'(rd_q.queue);
            sys_d = sys_q + ftss_pkg::SYS_W'(rd_q.standby);
            ph_d  = ftss_pkg::PH_XR;
          end
          ftss_pkg::PH_XR: begin
            sx2_d = sx2_q + ftss_pkg::SX2_W'(prod_q);
            ph_d  = ftss_pkg::PH_XQ;
          end
          ftss_pkg::PH_XQ: begin
            sxyr_d = sxyr_q + ftss_pkg::SXYR_W'(prod_q);
            ph_d   = ftss_pkg::PH_XS;
          end
          ftss_pkg::PH_XS: begin
            sxyq_d = sxyq_q + ftss_pkg::SXYQ_W'(prod_q);
            ph_d   = ftss_pkg::PH_ADD_S;
          end
          default: begin
            sxys_d = sxys_q + ftss_pkg::SXYS_W'(prod_q);
            ph_d   = ftss_pkg::PH_READ;
            ptr_d  = ptr_inc;
            idx_d  = idx_q + 1'b1;
            if (idx_q == fill_q - 1'b1) begin
              // n * sum(x^2)
              acc_d   = '0;
              mcand_d = W'(sx2_q);
              mplr_d  = ftss_pkg::MPLR_W'(fill_q);
              step_d  = ftss_pkg::STEP_NSX2;
            end
          end
        endcase
      end

      // shift-add multiply, one multiplier bit a cycle
      ftss_pkg::ST_MUL: begin
        if (mplr_q != '0) begin
          if (mplr_q[0]) acc_d = au_sum[W-1:0];
          mcand_d = mcand_q << 1;
          mplr_d  = mplr_q >> 1;
        end else begin
          case (step_q)
            ftss_pkg::STEP_NSX2: begin
              den_d   = acc_q;
              acc_d   = '0;
              mcand_d = W'(sx_q);
              mplr_d  = sx_q;
              step_d  = ftss_pkg::STEP_SXSX;
            end
            ftss_pkg::STEP_NSXY: begin
              a_d     = acc_q;
              acc_d   = '0;
              mcand_d = W'(sx_q);
              mplr_d  = ftss_pkg::MPLR_W'(sy_sel);
              step_d  = ftss_pkg::STEP_SXSY;
            end
            ftss_pkg::STEP_SCALE: begin
              wc_d  = den_zero_q ? '0 : acc_q;
              acc_d = '0;
              cnt_d = '0;
            end
            default: ;
          endcase
        end
      end

      ftss_pkg::ST_DEN_SUB: begin
        den_d      = au_sum[W-1:0];
        den_zero_d = (au_sum[W-1:0] == '0);
        fld_d      = 2'd0;
        acc_d      = '0;
        mcand_d    = W'(sxyr_q);
        mplr_d     = ftss_pkg::MPLR_W'(fill_q);
        step_d     = ftss_pkg::STEP_NSXY;
      end

      // magnitude and sign of n*sxy - sx*sy
      ftss_pkg::ST_MAG_SUB: begin
        a_d   = au_sum[W-1:0];
        neg_d = !au_ge;
        if (au_ge) begin
          acc_d   = '0;
          mcand_d = au_sum[W-1:0];
          mplr_d  = ftss_pkg::MPLR_W'(ftss_pkg::SLOPE_SCALE);
          step_d  = ftss_pkg::STEP_SCALE;
        end
      end
      ftss_pkg::ST_MAG_NEG: begin
        acc_d   = '0;
        mcand_d = au_sum[W-1:0];
        mplr_d  = ftss_pkg::MPLR_W'(ftss_pkg::SLOPE_SCALE);
        step_d  = ftss_pkg::STEP_SCALE;
      end

      // restoring division, one quotient bit a cycle
      ftss_pkg::ST_DIV: begin
        acc_d = au_ge ? au_sum[W-1:0] : {acc_q[W-2:0], wc_q[W-1]};
        wc_d  = {wc_q[W-2:0], au_ge};
        cnt_d = cnt_q + 1'b1;
      end

      ftss_pkg::ST_SAT: begin
        case (fld_q)
          2'd0:    hf_d = slope_sat;
          2'd1:    dq_d = slope_sat;
          default: sb_d = slope_sat;
        endcase
        fld_d   = fld_q + 1'b1;
        acc_d   = '0;
        mplr_d  = ftss_pkg::MPLR_W'(fill_q);
        mcand_d = (fld_q == 2'd0) ? W'(sxyq_q) : W'(sxys_q);
        step_d  = ftss_pkg::STEP_NSXY;
      end

      ftss_pkg::ST_RESULT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_user_d  = win_ok_q;
          if (win_ok_q) begin
            m_data_d = {7'd0, storm, conf, level, score, fcast, sb_q, dq_q, hf_q};
          end else begin
            m_data_d = '0;
          end
        end
      end

      default: ;
    endcase
  end

  // window memory write and registered read
  always_ff @(posedge clk_i) begin
    if (s_acc && (s_axis_tuser_i == ftss_pkg::MODE_PUSH)) begin
      mem[head_q] <= in_smp;
    end
    rd_q <= mem[ptr_q];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ftss_pkg::ST_IDLE;
      head_q    <= '0;
      fill_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      fill_q    <= fill_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    step_q <= step_d;  ph_q <= ph_d;    ptr_q <= ptr_d;  idx_q <= idx_d;
    fld_q <= fld_d;    cnt_q <= cnt_d;  t0_q <= t0_d;    x_q <= x_d;
    sx_q <= sx_d;      sx2_q <= sx2_d;
    syr_q <= syr_d;    syq_q <= syq_d;  sys_q <= sys_d;
    sxyr_q <= sxyr_d;  sxyq_q <= sxyq_d; sxys_q <= sxys_d;
    acc_q <= acc_d;    mcand_q <= mcand_d; mplr_q <= mplr_d;
    den_q <= den_d;    a_q <= a_d;      wc_q <= wc_d;
    den_zero_q <= den_zero_d;           neg_q <= neg_d;
    hf_q <= hf_d;      dq_q <= dq_d;    sb_q <= sb_d;
    rate_q <= rate_d;  queue_q <= queue_d; stby_q <= stby_d;
    win_ok_q <= win_ok_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    if (prod_en) prod_q <= mul_a * mul_b;
  end

`ifndef SYNTHESIS
  // fill never passes the window depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= ftss_pkg::FILL_W'(ftss_pkg::WINDOW_DEPTH))
    else $error("window fill beyond depth");

  // a result from fewer than three samples carries only zeros
  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_user_q) |-> (m_data_q == '0))
    else $error("short window result not zero");

  // score, level and confidence stay in range
  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> ((m_data_q[122:116] <= 7'd100) && (m_data_q[125:123] <= 3'd4) &&
                   (m_data_q[135:126] <= 10'd950)))
    else $error("result field out of range");

  // the input side is closed while a push is being worked on
  a_busy_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (s_axis_tuser_i == ftss_pkg::MODE_PUSH)) |=> !s_axis_tready_o)
    else $error("input taken while busy");
`endif

endmodule
